// File: src/table_interpolator_assert.svh
// ---------------------------------------------------------------------------
// Table interpolator assertion macros
// Shared same-cycle-implication and next-cycle-implication property macros.
// ---------------------------------------------------------------------------
`ifndef TABLE_INTERPOLATOR_ASSERT_SVH
`define TABLE_INTERPOLATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TBI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tbi_pkg.sv
// ---------------------------------------------------------------------------
// Table interpolator package
// Codes, constants and the request/status types of the arithmetic unit.
// ---------------------------------------------------------------------------
package tbi_pkg;

  localparam int DATA_W = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic METHOD_LINEAR = 1'b0;
  localparam logic METHOD_CONST  = 1'b1;

  localparam logic [16:0] FRAC_ONE = 17'h10000;

  localparam logic [2:0] REG_METHOD      = 3'd0;
  localparam logic [2:0] REG_FRACTION    = 3'd1;
  localparam logic [2:0] REG_LEFT_VALUE  = 3'd2;
  localparam logic [2:0] REG_RIGHT_VALUE = 3'd3;
  localparam logic [2:0] REG_POINT_COUNT = 3'd4;

  typedef struct packed {
    logic              start;
    logic              method;
    logic [16:0]       frac;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] xi;
    logic [DATA_W-1:0] xj;
    logic [DATA_W-1:0] yi;
    logic [DATA_W-1:0] yj;
  } arith_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] result;
  } arith_sts_t;

endpackage

// File: src/table_interpolator.sv
// ---------------------------------------------------------------------------
// Table interpolator
// Piecewise linear or step-blend lookup over a table of Q16.16 points.
// Input stream: s_axis_tuser selects a point load or a query; loads write
// one table entry and give no result, queries give one result on m_axis.
// A query reads the table once per cycle through the single memory read
// port: first and last point, one bisection read per halving, then both
// bracketing points. A query below the first point or above the last point
// ends after that compare, and one that lands on a point or in a zero-width
// interval ends after the bracketing reads. Any other query then uses the
// arithmetic unit: constant mode for the multiplier pass, linear mode for
// that pass and the bit-serial divide (one quotient bit per cycle).
// s_axis_tready is low while a query runs. A finished result waits in the
// output register; a stalled receiver holds it and the block still takes
// the next request meanwhile. Registers are to be written over the APB
// port only while no query is running; the user is bound by this, as the
// block does not enforce it. Reset clears control state and the registers;
// table entries stay undefined until loaded.
// ---------------------------------------------------------------------------
`include "table_interpolator_assert.svh"

module table_interpolator #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // point_index[7:0], x_value[39:8], y_value[71:40]
  input  logic        s_axis_tuser,  // operation[0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_value[31:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
  localparam int W = tbi_pkg::DATA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_LASTPT = 3'd2;
  localparam logic [2:0] S_BISECT = 3'd3;
  localparam logic [2:0] S_RDI    = 3'd4;
  localparam logic [2:0] S_RDJ    = 3'd5;
  localparam logic [2:0] S_ARITH  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic              method_q;
  logic [16:0]       fraction_q;
  logic [W-1:0]      left_q;
  logic [W-1:0]      right_q;
  logic [8:0]        point_count_q;
  logic              cfg_wr;

  logic [2:0]        state_q, state_d;
  logic [IdxW-1:0]   i_q, i_d, j_q, j_d, mid_q, mid_d;
  logic [IdxW-1:0]   i_n, j_n, j0, mid_n, rd_addr;
  logic [IdxW:0]     pair_sum;
  logic              span_ok;
  logic signed [W-1:0] v_q, v_d;
  logic              last_q, last_d;
  logic [W-1:0]      xi_q, xi_d, yi_q, yi_d;
  logic [W-1:0]      res_q, res_d;
  logic [16:0]       frac_sat;

  logic              in_acc;
  logic              wr_en;
  logic [2*W-1:0]    rd_data;
  logic signed [W-1:0] rd_x;
  logic [W-1:0]      rd_y;
  logic              v_lt, v_gt;
  logic              out_free;
  logic              m_valid_q;
  logic [W-1:0]      m_data_q;
  logic              m_last_q;

  tbi_pkg::arith_req_t arith_req;
  tbi_pkg::arith_sts_t arith_sts;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q      <= tbi_pkg::METHOD_LINEAR;
      fraction_q    <= '0;
      left_q        <= '0;
      right_q       <= '0;
      point_count_q <= 9'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        tbi_pkg::REG_METHOD:      method_q      <= pwdata[0];
        tbi_pkg::REG_FRACTION:    fraction_q    <= pwdata[16:0];
        tbi_pkg::REG_LEFT_VALUE:  left_q        <= pwdata;
        tbi_pkg::REG_RIGHT_VALUE: right_q       <= pwdata;
        tbi_pkg::REG_POINT_COUNT: point_count_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      tbi_pkg::REG_METHOD:      prdata = {31'd0, method_q};
      tbi_pkg::REG_FRACTION:    prdata = {15'd0, fraction_q};
      tbi_pkg::REG_LEFT_VALUE:  prdata = left_q;
      tbi_pkg::REG_RIGHT_VALUE: prdata = right_q;
      tbi_pkg::REG_POINT_COUNT: prdata = {23'd0, point_count_q};
      default:                  prdata = '0;
    endcase
  end

  assign frac_sat = (fraction_q > tbi_pkg::FRAC_ONE) ? tbi_pkg::FRAC_ONE : fraction_q;

  always_comb begin
    if (point_count_q == '0) begin
      j0 = '0;
    end else if (32'(point_count_q) > 32'(TABLE_DEPTH)) begin
      j0 = LastIdx;
    end else begin
      j0 = IdxW'(point_count_q - 9'd1);
    end
  end

  // Table storage
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign wr_en  = in_acc && (s_axis_tuser == tbi_pkg::OP_LOAD) &&
                  (32'(s_axis_tdata[7:0]) < 32'(TABLE_DEPTH));

  tbi_point_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_point_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IdxW'(s_axis_tdata[7:0])),
    .wr_data_i ({s_axis_tdata[71:40], s_axis_tdata[39:8]}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_x = rd_data[W-1:0];
  assign rd_y = rd_data[2*W-1:W];
  assign v_lt = v_q < rd_x;
  assign v_gt = v_q > rd_x;

  // Bisection bounds after this cycle's compare
  always_comb begin
    i_n = i_q;
    j_n = j_q;
    if (state_q == S_BISECT) begin
      if (v_lt) begin
        j_n = mid_q;
      end else begin
        i_n = mid_q;
      end
    end
  end

  assign pair_sum = {1'b0, i_n} + {1'b0, j_n};
  assign mid_n    = pair_sum[IdxW:1];
  assign span_ok  = ({1'b0, i_n} + {{IdxW{1'b0}}, 1'b1}) < {1'b0, j_n};

  // Sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    mid_d   = mid_q;
    v_d     = v_q;
    last_d  = last_q;
    xi_d    = xi_q;
    yi_d    = yi_q;
    res_d   = res_q;
    rd_addr = '0;
    arith_req.start  = 1'b0;
    arith_req.method = method_q;
    arith_req.frac   = frac_sat;
    arith_req.v      = v_q;
    arith_req.xi     = xi_q;
    arith_req.xj     = rd_x;
    arith_req.yi     = yi_q;
    arith_req.yj     = rd_y;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == tbi_pkg::OP_QUERY)) begin
          v_d     = s_axis_tdata[39:8];
          last_d  = s_axis_tlast;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        i_d     = '0;
        j_d     = j0;
        rd_addr = j0;
        if (v_lt) begin
          res_d   = left_q;
          state_d = S_EMIT;
        end else begin
          state_d = S_LASTPT;
        end
      end
      S_LASTPT, S_BISECT: begin
        i_d = i_n;
        j_d = j_n;
        if ((state_q == S_LASTPT) && v_gt) begin
          res_d   = right_q;
          state_d = S_EMIT;
        end else if (span_ok) begin
          mid_d   = mid_n;
          rd_addr = mid_n;
          state_d = S_BISECT;
        end else begin
          rd_addr = i_n;
          state_d = S_RDI;
        end
      end
      S_RDI: begin
        xi_d    = rd_x;
        yi_d    = rd_y;
        rd_addr = j_q;
        state_d = S_RDJ;
      end
      S_RDJ: begin
        if (v_q == $signed(xi_q)) begin
          res_d   = yi_q;
          state_d = S_EMIT;
        end else if (v_q == rd_x) begin
          res_d   = rd_y;
          state_d = S_EMIT;
        end else if (xi_q == rd_data[W-1:0]) begin
          res_d   = yi_q;
          state_d = S_EMIT;
        end else begin
          arith_req.start = 1'b1;
          state_d = S_ARITH;
        end
      end
      S_ARITH: begin
        if (arith_sts.done) begin
          res_d   = arith_sts.result;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    mid_q  <= mid_d;
    v_q    <= v_d;
    last_q <= last_d;
    xi_q   <= xi_d;
    yi_q   <= yi_d;
    res_q  <= res_d;
  end

  tbi_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .sts_o  (arith_sts)
  );

  // Output register
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == S_EMIT) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_EMIT) && out_free) begin
      m_data_q <= res_q;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  `TBI_ASSERT_NOW(a_bisect_order, clk_i, rst_ni, state_q == S_BISECT,
    (i_q < mid_q) && (mid_q < j_q), "bisection bounds out of order")
  `TBI_ASSERT_NOW(a_done_in_arith, clk_i, rst_ni, arith_sts.done, state_q == S_ARITH,
    "arithmetic done outside wait state")
  `TBI_ASSERT_NOW(a_start_unit_free, clk_i, rst_ni, arith_req.start, !arith_sts.busy,
    "arithmetic request while unit busy")
  `TBI_ASSERT_NEXT(a_emit_hold, clk_i, rst_ni, (state_q == S_EMIT) && !out_free,
    (state_q == S_EMIT) && $stable(res_q), "pending result lost under stall")

endmodule

// File: src/tbi_point_mem.sv
// ---------------------------------------------------------------------------
// Table interpolator point memory
// One write port and one registered read port holding {y, x} per point.
// ---------------------------------------------------------------------------
module tbi_point_mem #(
  parameter int TABLE_DEPTH = 256,
  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [IdxW-1:0]            wr_addr_i,
  input  logic [2*tbi_pkg::DATA_W-1:0] wr_data_i,
  input  logic [IdxW-1:0]            rd_addr_i,
  output logic [2*tbi_pkg::DATA_W-1:0] rd_data_o
);

  logic [2*tbi_pkg::DATA_W-1:0] mem_q [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// File: src/tbi_arith.sv
// ---------------------------------------------------------------------------
// Table interpolator arithmetic unit
// One multiplier pass, then a bit-serial restoring divide for linear mode.
// ---------------------------------------------------------------------------
`include "table_interpolator_assert.svh"

module tbi_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbi_pkg::arith_req_t req_i,
  output tbi_pkg::arith_sts_t sts_o
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;
  localparam logic [1:0] A_FIN  = 2'd3;

  localparam int W = tbi_pkg::DATA_W;
  localparam int CntW = $clog2(W);

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic signed [W:0]   op_a_q, op_a_d;
  logic signed [W:0]   op_b_q, op_b_d;
  logic [W-1:0]        dx_q, dx_d;
  logic [W-1:0]        yi_q, yi_d;
  logic                neg_q, neg_d;
  logic                method_q, method_d;
  logic [2*W-1:0]      acc_q, acc_d;

  logic [W:0]            dy;
  logic [W:0]            mag;
  logic signed [2*W+1:0] prod;
  logic [W:0]            rem2;
  logic [W:0]            diff;
  logic                  ge;

  assign dy   = {req_i.yj[W-1], req_i.yj} - {req_i.yi[W-1], req_i.yi};
  assign mag  = dy[W] ? ((W+1)'(0) - dy) : dy;
  assign prod = op_a_q * op_b_q;
  assign rem2 = acc_q[2*W-1:W-1];
  assign diff = rem2 - {1'b0, dx_q};
  assign ge   = (rem2 >= {1'b0, dx_q});

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    op_a_d   = op_a_q;
    op_b_d   = op_b_q;
    dx_d     = dx_q;
    yi_d     = yi_q;
    neg_d    = neg_q;
    method_d = method_q;
    acc_d    = acc_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          method_d = req_i.method;
          yi_d     = req_i.yi;
          neg_d    = dy[W];
          dx_d     = req_i.xj - req_i.xi;
          if (req_i.method == tbi_pkg::METHOD_LINEAR) begin
            op_a_d = {1'b0, mag[W-1:0]};
            op_b_d = {1'b0, req_i.v - req_i.xi};
          end else begin
            op_a_d = dy;
            op_b_d = {{(W-16){1'b0}}, req_i.frac};
          end
          state_d = A_MUL;
        end
      end
      A_MUL: begin
        acc_d = prod[2*W-1:0];
        cnt_d = '0;
        state_d = (method_q == tbi_pkg::METHOD_LINEAR) ? A_DIV : A_FIN;
      end
      A_DIV: begin
        acc_d = {(ge ? diff[W-1:0] : rem2[W-1:0]), acc_q[W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(W-1)) begin
          state_d = A_FIN;
        end
      end
      A_FIN: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    op_a_q   <= op_a_d;
    op_b_q   <= op_b_d;
    dx_q     <= dx_d;
    yi_q     <= yi_d;
    neg_q    <= neg_d;
    method_q <= method_d;
    acc_q    <= acc_d;
  end

  always_comb begin
    sts_o.busy = (state_q != A_IDLE);
    sts_o.done = (state_q == A_FIN);
    if (method_q == tbi_pkg::METHOD_CONST) begin
      sts_o.result = yi_q + acc_q[W+15:16];
    end else if (neg_q) begin
      sts_o.result = yi_q - acc_q[W-1:0];
    end else begin
      sts_o.result = yi_q + acc_q[W-1:0];
    end
  end

  `TBI_ASSERT_NOW(a_div_rem_below_dx, clk_i, rst_ni, state_q == A_DIV, acc_q[2*W-1:W] < dx_q, "partial remainder not below divisor")
  `TBI_ASSERT_NOW(a_start_when_idle, clk_i, rst_ni, req_i.start, state_q == A_IDLE, "start while unit busy")
  `TBI_ASSERT_NOW(a_div_linear_only, clk_i, rst_ni, state_q == A_DIV, method_q == tbi_pkg::METHOD_LINEAR, "divide in constant mode")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Table interpolator testbench
// Streams point loads and queries into the block, switches the registers
// between phases over APB, and checks every result against a given value
// or an in-bench model of the bisection search and both blend modes.
// ---------------------------------------------------------------------------
module testbench;

  localparam int     ITEM_TARGET = 1900;
  localparam int     QUIET_FROM  = ITEM_TARGET - 150;
  localparam int     IDLE_CYCLES = 64;
  localparam int     HOLD_CYCLES = 400;
  localparam int     DRAIN_LIMIT = 20000;
  localparam longint X_MIN       = -64'sd2147483648;
  localparam longint X_MAX       = 64'sd2147483647;

  typedef struct {
    logic [31:0] value;
    logic        lst;
  } result_t;

  typedef struct {
    logic        is_cfg;
    logic [2:0]  reg_sel;
    logic        op;
    logic [7:0]  idx;
    logic [31:0] xv;
    logic [31:0] yv;
    logic        lst;
    logic        has_exp;
    logic [31:0] exp_val;
  } plan_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;  // point_index[7:0], x_value[39:8], y_value[71:40]
  logic        s_axis_tuser  = tbi_pkg::OP_LOAD;  // operation[0]
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;  // result_value[31:0]
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  logic signed [31:0] tbl_x [256];
  logic        [31:0] tbl_y [256];
  logic               cfg_method;
  logic        [16:0] cfg_fraction;
  logic        [31:0] cfg_left;
  logic        [31:0] cfg_right;
  logic        [8:0]  cfg_count;

  result_t   pending_results [$];
  plan_row_t plan [$];
  int        fail_count = 0;
  int        n_items    = 0;
  logic      quiet      = 1'b0;
  logic      calm       = 1'b0;
  logic      hold_req   = 1'b0;

  table_interpolator #(
    .TABLE_DEPTH(256)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] interp_value(input logic signed [31:0] v);
    int                n, i, j, mid;
    longint            xi, xj, yi, yj, dy, fl, s;
    longint unsigned   mag, dv, dx, q;
    logic       [16:0] f;
    n = (cfg_count == 9'd0) ? 1 : (cfg_count > 9'd256) ? 256 : int'(cfg_count);
    i = 0;
    j = n - 1;
    if (v < tbl_x[0]) return cfg_left;
    if (v > tbl_x[j]) return cfg_right;
    while (i + 1 < j) begin
      mid = (i + j) / 2;
      if (v < tbl_x[mid]) j = mid;
      else i = mid;
    end
    if (v == tbl_x[i]) return tbl_y[i];
    if (v == tbl_x[j]) return tbl_y[j];
    if (tbl_x[i] == tbl_x[j]) return tbl_y[i];
    xi = tbl_x[i];
    xj = tbl_x[j];
    yi = longint'(signed'(tbl_y[i]));
    yj = longint'(signed'(tbl_y[j]));
    if (cfg_method == tbi_pkg::METHOD_LINEAR) begin
      dy  = yj - yi;
      dv  = v - xi;
      dx  = xj - xi;
      mag = (dy < 0) ? -dy : dy;
      q   = (mag * dv) / dx;
      return (dy < 0) ? 32'(yi - longint'(q)) : 32'(yi + longint'(q));
    end
    f  = (cfg_fraction > tbi_pkg::FRAC_ONE) ? tbi_pkg::FRAC_ONE : cfg_fraction;
    fl = longint'(f);
    s  = yi * (64'sd65536 - fl) + yj * fl;
    return 32'(s >>> 16);
  endfunction

  function automatic logic [31:0] pick_edge_value();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Hold off the input until all results are back and the block is quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (IDLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] sel, input logic [31:0] data);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (sel)
      tbi_pkg::REG_METHOD:      cfg_method   = data[0];
      tbi_pkg::REG_FRACTION:    cfg_fraction = data[16:0];
      tbi_pkg::REG_LEFT_VALUE:  cfg_left     = data;
      tbi_pkg::REG_RIGHT_VALUE: cfg_right    = data;
      tbi_pkg::REG_POINT_COUNT: cfg_count    = data[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_req(input logic op, input logic [7:0] idx, input logic [31:0] xv,
                          input logic [31:0] yv, input logic lst, input logic has_exp,
                          input logic [31:0] exp_val);
    result_t entry;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {yv, xv, idx};
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == tbi_pkg::OP_LOAD) begin
      tbl_x[idx] = xv;
      tbl_y[idx] = yv;
    end else begin
      entry.value = has_exp ? exp_val : interp_value(xv);
      entry.lst   = lst;
      pending_results.push_back(entry);
    end
    n_items++;
    if (n_items >= QUIET_FROM) quiet = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic add_load(input logic [7:0] idx, input logic [31:0] xv, input logic [31:0] yv);
    plan_row_t row;
    row = '{is_cfg: 1'b0, reg_sel: tbi_pkg::REG_METHOD, op: tbi_pkg::OP_LOAD, idx: idx,
            xv: xv, yv: yv, lst: 1'b0, has_exp: 1'b0, exp_val: '0};
    plan.push_back(row);
  endtask

  task automatic add_query(input logic [31:0] v, input logic lst, input logic has_exp,
                           input logic [31:0] exp_val);
    plan_row_t row;
    row = '{is_cfg: 1'b0, reg_sel: tbi_pkg::REG_METHOD, op: tbi_pkg::OP_QUERY, idx: 8'hA5,
            xv: v, yv: 32'h5A5A_5A5A, lst: lst, has_exp: has_exp, exp_val: exp_val};
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [2:0] sel, input logic [31:0] data);
    plan_row_t row;
    row = '{is_cfg: 1'b1, reg_sel: sel, op: tbi_pkg::OP_LOAD, idx: '0, xv: data, yv: '0,
            lst: 1'b0, has_exp: 1'b0, exp_val: '0};
    plan.push_back(row);
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result value=%h last=%b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tlast !== want.lst) begin
          note_fail($sformatf("result mismatch: expected value=%h last=%b, got value=%h last=%b",
                              want.value, want.lst, m_axis_tdata, m_axis_tlast));
        end
      end
    end
  end

  initial begin : ready_drive
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready <= 1'b1;
        hold_req = 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                phase_no, eff_n, n_query, style, k, k2, r, w;
    logic        [8:0] cnt;
    logic       [16:0] frac;
    logic       [31:0] xv, v;
    longint            xk, a, b;
    longint unsigned   step_max, room;

    cfg_method   = tbi_pkg::METHOD_LINEAR;
    cfg_fraction = '0;
    cfg_left     = '0;
    cfg_right    = '0;
    cfg_count    = 9'd1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_load(8'd0, 32'h0000_0000, 32'h0001_0000);
    add_query(32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000);
    add_query(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000);
    add_query(32'h0000_0000, 1'b1, 1'b1, 32'h0001_0000);
    add_cfg(tbi_pkg::REG_LEFT_VALUE, 32'h8000_0000);
    add_cfg(tbi_pkg::REG_RIGHT_VALUE, 32'h7FFF_FFFF);
    add_cfg(tbi_pkg::REG_POINT_COUNT, 32'd4);
    add_load(8'd1, 32'h0001_0000, 32'h7FFF_FFFF);
    add_load(8'd2, 32'h0002_0000, 32'h8000_0000);
    add_load(8'd3, 32'h7FFF_FFFF, 32'h0000_0000);
    add_query(32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000);
    add_query(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000);
    add_query(32'h0000_8000, 1'b0, 1'b0, '0);
    add_query(32'h0001_8000, 1'b0, 1'b0, '0);
    add_query(32'h4000_0000, 1'b1, 1'b0, '0);
    add_cfg(tbi_pkg::REG_METHOD, 32'(tbi_pkg::METHOD_CONST));
    add_cfg(tbi_pkg::REG_FRACTION, 32'd0);
    add_query(32'h0000_8000, 1'b0, 1'b1, 32'h0001_0000);
    add_cfg(tbi_pkg::REG_FRACTION, 32'(tbi_pkg::FRAC_ONE));
    add_query(32'h0000_8000, 1'b1, 1'b1, 32'h7FFF_FFFF);
    // fraction above one saturates to the right ordinate
    add_cfg(tbi_pkg::REG_FRACTION, 32'h0001_FFFF);
    add_query(32'h0001_8000, 1'b0, 1'b1, 32'h8000_0000);
    add_cfg(tbi_pkg::REG_FRACTION, 32'h0000_8000);
    add_query(32'h0001_8000, 1'b1, 1'b0, '0);
    // unsorted table
    add_load(8'd1, 32'h0003_0000, 32'h0005_0000);
    add_query(32'h0002_8000, 1'b0, 1'b0, '0);
    add_query(32'h0000_8000, 1'b1, 1'b0, '0);
    // point count zero acts as one
    add_cfg(tbi_pkg::REG_POINT_COUNT, 32'd0);
    add_query(32'h0000_0000, 1'b0, 1'b1, 32'h0001_0000);
    add_query(32'h0000_0005, 1'b1, 1'b1, 32'h7FFF_FFFF);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_sel, plan[i].xv);
      else push_req(plan[i].op, plan[i].idx, plan[i].xv, plan[i].yv, plan[i].lst,
                    plan[i].has_exp, plan[i].exp_val);
    end

    phase_no = 0;
    while (n_items < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        cnt = 9'd256;
      end else if (phase_no == 6) begin
        cnt = 9'd511;
      end else begin
        r   = $urandom_range(0, 9);
        cnt = (r == 0) ? 9'd1 : (r == 1) ? 9'd2 : 9'($urandom_range(3, 12));
      end
      eff_n = (cnt > 9'd256) ? 256 : int'(cnt);
      r = $urandom_range(0, 4);
      case (r)
        0:       frac = 17'd0;
        1:       frac = tbi_pkg::FRAC_ONE;
        2:       frac = 17'($urandom_range(65537, 131071));
        default: frac = 17'($urandom_range(0, 65536));
      endcase
      write_reg(tbi_pkg::REG_METHOD, 32'($urandom_range(0, 1)));
      write_reg(tbi_pkg::REG_FRACTION, {15'd0, frac});
      write_reg(tbi_pkg::REG_LEFT_VALUE, pick_edge_value());
      write_reg(tbi_pkg::REG_RIGHT_VALUE, pick_edge_value());
      write_reg(tbi_pkg::REG_POINT_COUNT, {23'd0, cnt});
      if (phase_no == 3) hold_req = 1'b1;

      // ascending abscissas, with repeats in one style and no order in another
      style = $urandom_range(0, 5);
      if ($urandom_range(0, 1) == 1) step_max = 64'($urandom_range(1, 32'h0004_0000));
      else step_max = 64'hFFFF_FFFF / eff_n;
      room = 64'hFFFF_FFFF - step_max * 64'(eff_n - 1);
      xk   = X_MIN + longint'({$urandom, $urandom} % (room + 1));
      for (k = 0; k < eff_n; k++) begin
        if (k > 0 && !(style == 5 && $urandom_range(0, 2) == 0))
          xk = xk + longint'({$urandom, $urandom} % (step_max + 1));
        xv = (style == 4) ? $urandom : xk[31:0];
        push_req(tbi_pkg::OP_LOAD, 8'(k), xv, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
      end

      n_query = $urandom_range(8, 30);
      for (k = 0; k < n_query; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_req(tbi_pkg::OP_LOAD, 8'($urandom_range(0, 255)), $urandom, $urandom,
                   1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          a = tbl_x[0];
          b = tbl_x[eff_n-1];
          r = $urandom_range(0, 9);
          case (r)
            0: v = (a > X_MIN) ?
                   32'(a - 1 - longint'({$urandom, $urandom} % 64'(a - X_MIN))) : 32'(a);
            1: v = (b < X_MAX) ?
                   32'(b + 1 + longint'({$urandom, $urandom} % 64'(X_MAX - b))) : 32'(b);
            2: v = tbl_x[$urandom_range(0, eff_n - 1)];
            3: v = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: begin
              v = $urandom;
              if (eff_n > 1) begin
                k2 = $urandom_range(0, eff_n - 2);
                a  = tbl_x[k2];
                b  = tbl_x[k2+1];
                if (b > a) v = 32'(a + longint'({$urandom, $urandom} % 64'(b - a + 1)));
              end
            end
          endcase
          push_req(tbi_pkg::OP_QUERY, 8'($urandom), v, $urandom,
                   (k == n_query - 1) || ($urandom_range(0, 3) == 0), 1'b0, '0);
        end
      end
      phase_no++;
    end

    s_axis_tvalid <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) @(negedge clk_i);
    repeat (IDLE_CYCLES) @(negedge clk_i);
    if (pending_results.size() != 0)
      note_fail($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/tbi_pkg.sv
src/tbi_point_mem.sv
src/tbi_arith.sv
src/table_interpolator.sv
tb/sv/testbench.sv
